// File: rtl/ibds_pkg.sv
// Shared types, constants and helpers for the I2C bus divider search unit.
package ibds_pkg;

    localparam logic [31:0] CLK_RESET     = 32'd400000000;
    // filter = (5 * (clk / 1000)) / 100000 collapses to clk / 20000000
    localparam logic [24:0] FILT_DIVISOR  = 25'd20000000;
    // clk / 20e6 = (clk >> 8) / 78125, taken as a multiply by 2^41 / 78125 rounded up
    localparam int          FILT_PRESHIFT = 8;
    localparam logic [24:0] FILT_RECIP    = 25'd28147498;
    localparam int          FILT_SHIFT    = 41;
    localparam logic [7:0]  FILT_RESET    = 8'(CLK_RESET / 32'(FILT_DIVISOR));
    localparam logic [5:0]  DEFAULT_CODE  = 6'h31;
    localparam logic [15:0] TARGET_MAX    = 16'hFFFF;
    localparam int          NUM_A         = 8;
    localparam int          NUM_B         = 8;
    localparam int          B_BASE_SHIFT  = 4;

    typedef struct packed {
        logic        found;
        logic [15:0] cand;
        logic [2:0]  aidx;
        logic [2:0]  gidx;
    } t_pick;

    typedef struct packed {
        logic [7:0]  filter_count;
        logic [5:0]  divider_code;
        logic [31:0] actual_speed_hz;
        logic        divisor_found;
    } t_result;

    function automatic logic [4:0] a_value(input logic [2:0] idx);
        logic [4:0] v;
        case (idx)
            3'd0:    v = 5'd10;
            3'd1:    v = 5'd12;
            3'd2:    v = 5'd14;
            3'd3:    v = 5'd16;
            3'd4:    v = 5'd18;
            3'd5:    v = 5'd20;
            3'd6:    v = 5'd24;
            default: v = 5'd30;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ibds_if.sv
// Handshake channel interfaces: request, result and configuration write.
interface ibds_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] requested_speed_hz;
    modport source (output valid, output requested_speed_hz, input ready);
    modport sink   (input valid, input requested_speed_hz, output ready);
endinterface

interface ibds_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  filter_count;
    logic [5:0]  divider_code;
    logic [31:0] actual_speed_hz;
    logic        divisor_found;
    modport source (output valid, output filter_count, output divider_code,
                    output actual_speed_hz, output divisor_found, input ready);
    modport sink   (input valid, input filter_count, input divider_code,
                    input actual_speed_hz, input divisor_found, output ready);
endinterface

interface ibds_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ibds_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ibds_div #(
    parameter int DW = 32,
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_num  [DW];
    logic [VW-1:0] r_rem  [DW];
    logic [VW-1:0] r_den  [DW];
    logic [SW-1:0] r_side [DW];
    logic          r_v    [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic [DW-1:0] p_num;
        logic [VW-1:0] p_rem;
        logic [VW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic          p_v;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign p_num  = i_dividend;
            assign p_rem  = '0;
            assign p_den  = i_divisor;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_num  = r_num[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_den  = r_den[s-1];
            assign p_side = r_side[s-1];
            assign p_v    = r_v[s-1];
        end

        assign trial = {p_rem, p_num[DW-1]};
        assign diff  = trial - {1'b0, p_den};
        assign ge    = trial >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s]  <= {p_num[DW-2:0], ge};
                r_rem[s]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_quot  = r_num[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

// File: rtl/ibds_search.sv
// Candidate divisor search: per-A lanes, then a registered minimum tree.
module ibds_search
    import ibds_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [15:0]   i_target,
    input  logic [7:0]    i_filt,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output t_pick         o_pick,
    output logic [SW-1:0] o_side
);

    t_pick         n_lane [NUM_A];
    t_pick         r_l0   [NUM_A];
    t_pick         r_l1   [4];
    t_pick         r_l2   [2];
    t_pick         r_l3;
    logic [3:0]    r_v;
    logic [SW-1:0] r_side [4];

    // left has the lower A index and wins a tie
    function automatic t_pick pick2(input t_pick l, input t_pick r);
        if (l.found && (!r.found || l.cand <= r.cand)) begin
            return l;
        end
        return r;
    endfunction

    // candidates rise with g, so the lowest hitting g is the lane minimum
    always_comb begin
        logic [9:0]  tf;
        logic [9:0]  q;
        logic [10:0] m;
        logic [16:0] c;
        tf = 10'(3 * i_filt);
        for (int a = 0; a < NUM_A; a++) begin
            n_lane[a] = '0;
            n_lane[a].aidx = 3'(a);
            for (int g = NUM_B - 1; g >= 0; g--) begin
                q = tf >> (B_BASE_SHIFT + g);
                m = 11'(a_value(3'(a))) + {q, 1'b0};
                c = 17'(m) << (B_BASE_SHIFT + g);
                if (c > {1'b0, i_target}) begin
                    n_lane[a].found = 1'b1;
                    n_lane[a].cand  = c[15:0];
                    n_lane[a].gidx  = 3'(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < NUM_A; a++) begin
                r_l0[a] <= n_lane[a];
            end
            for (int k = 0; k < 4; k++) begin
                r_l1[k] <= pick2(r_l0[2*k], r_l0[2*k+1]);
            end
            for (int k = 0; k < 2; k++) begin
                r_l2[k] <= pick2(r_l1[2*k], r_l1[2*k+1]);
            end
            r_l3      <= pick2(r_l2[0], r_l2[1]);
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_pick  = r_l3;
    assign o_side  = r_side[3];

endmodule

// File: rtl/i2c_bus_divider_search_unit.sv
// Top level of the I2C bus divider search unit.
// One request transaction enters per clock unless the pipeline is frozen,
// and its result leaves after the clock/speed divider (one quotient bit per
// stage), the candidate lanes and minimum tree, and the clock/divisor divider
// giving the achieved speed. Sustained rate is one transaction per cycle
// while the output buffer takes results. The filter count only depends on
// the input clock, so it is worked out when the clock register is written
// and travels with each request. A two-entry output buffer lets the pipeline
// keep moving while a result waits; when it is full and a further result is
// ready to enter, the whole pipeline freezes for that cycle. The input clock
// register is written through the config channel, which is always ready;
// write it only while the unit is idle.
module i2c_bus_divider_search_unit
    import ibds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ibds_req_if.sink    i_req,
    ibds_cfg_if.sink    i_cfg,
    ibds_res_if.source  o_res
);

    logic [31:0] r_clk_hz;
    logic [7:0]  r_filt;
    logic [7:0]  n_filt;
    logic [48:0] filt_prod;
    logic        en;

    // front divider: target = clk / req, with clock, speed and filter alongside
    logic        tdiv_v;
    logic [31:0] tdiv_q;
    logic [71:0] tdiv_side;

    logic [15:0] target;
    logic [7:0]  filt;

    logic        srch_v;
    t_pick       srch_pick;
    logic [71:0] srch_side;

    logic [5:0]  code;
    logic        sdiv_v;
    logic [31:0] sdiv_q;
    logic [46:0] sdiv_side;
    t_result     res;

    t_result     r_buf0;
    t_result     r_buf1;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign i_cfg.ready = 1'b1;

    // filter = clk / 20e6 by reciprocal multiply, raised to at least one
    assign filt_prod = 49'(i_cfg.data[31:FILT_PRESHIFT]) * 49'(FILT_RECIP);
    assign n_filt    = (filt_prod[FILT_SHIFT +: 8] == 8'd0) ? 8'd1
                                                            : filt_prod[FILT_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
            r_filt   <= FILT_RESET;
        end else if (i_cfg.valid) begin
            r_clk_hz <= i_cfg.data;
            r_filt   <= n_filt;
        end
    end

    // whole pipeline advances unless a result is due and the buffer is full
    assign en          = !sdiv_v || (r_cnt != 2'd2);
    assign i_req.ready = en;

    ibds_div #(.DW(32), .VW(32), .SW(72)) u_tdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_dividend (r_clk_hz),
        .i_divisor  (i_req.requested_speed_hz),
        .i_side     ({r_clk_hz, i_req.requested_speed_hz, r_filt}),
        .o_valid    (tdiv_v),
        .o_quot     (tdiv_q),
        .o_side     (tdiv_side)
    );

    // zero speed gives an all-ones quotient, which saturates as well
    assign target = (|tdiv_q[31:16]) ? TARGET_MAX : tdiv_q[15:0];
    assign filt   = tdiv_side[7:0];

    ibds_search #(.SW(72)) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (tdiv_v),
        .i_target (target),
        .i_filt   (filt),
        .i_side   (tdiv_side),
        .o_valid  (srch_v),
        .o_pick   (srch_pick),
        .o_side   (srch_side)
    );

    // code = {A group bit 2, g, A group bits 1:0}, group = 4 + A index
    assign code = srch_pick.found
                ? {~srch_pick.aidx[2], srch_pick.gidx, srch_pick.aidx[1:0]}
                : DEFAULT_CODE;

    ibds_div #(.DW(32), .VW(16), .SW(47)) u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (srch_v),
        .i_dividend (srch_side[71:40]),
        .i_divisor  (srch_pick.cand),
        .i_side     ({srch_side[7:0], code, srch_pick.found, srch_side[39:8]}),
        .o_valid    (sdiv_v),
        .o_quot     (sdiv_q),
        .o_side     (sdiv_side)
    );

    always_comb begin
        res.filter_count    = sdiv_side[46:39];
        res.divider_code    = sdiv_side[38:33];
        res.divisor_found   = sdiv_side[32];
        res.actual_speed_hz = sdiv_side[32] ? sdiv_q : sdiv_side[31:0];
    end

    // two-entry output buffer
    assign push = sdiv_v && en;
    assign pop  = (r_cnt != 2'd0) && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_buf0 <= r_buf1;
                if (push) begin
                    r_buf1 <= res;
                end
            end else if (push) begin
                r_buf0 <= res;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_buf0 <= res;
            end else begin
                r_buf1 <= res;
            end
        end
    end

    assign o_res.valid           = (r_cnt != 2'd0);
    assign o_res.filter_count    = r_buf0.filter_count;
    assign o_res.divider_code    = r_buf0.divider_code;
    assign o_res.actual_speed_hz = r_buf0.actual_speed_hz;
    assign o_res.divisor_found   = r_buf0.divisor_found;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && (r_cnt == 2'd2) && !pop))
        else $error("output buffer overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sdiv_v && (r_cnt == 2'd2) && !o_res.ready) |-> !i_req.ready)
        else $error("request taken while pipeline stalled");

    a_default_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.divisor_found) |-> (o_res.divider_code == DEFAULT_CODE))
        else $error("default code missing");
`endif

endmodule

// File: tb/sv/tb_i2c_bus_divider_search_unit.sv
// Self-checking testbench for the I2C bus divider search unit.
`timescale 1ns / 1ps

module tb_i2c_bus_divider_search_unit
    import ibds_pkg::*;
();

    localparam int LATENCY_SLACK = 90;     // pipeline is 68 deep plus output buffer
    localparam int CYCLE_LIMIT   = 400000;

    logic i_clk;
    logic i_rst_n;

    ibds_req_if req_ch();
    ibds_cfg_if cfg_ch();
    ibds_res_if res_ch();

    i2c_bus_divider_search_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    // Clock frequency as the unit currently sees it
    logic [31:0] clk_hz_shadow;

    logic [31:0] pending_speeds[$];     // requests waiting to be offered
    t_result     expected_results[$];   // divider picks still owed by the unit

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  tx_pause;      // sender holds off entirely
    bit  rx_hold;       // receiver holds off entirely
    int  error_count;
    int  accepted_count;
    int  result_count;
    int  found_count;
    int  cycle_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Work out the divider pick for one requested speed at the given clock.
    function automatic t_result pick_divider(input logic [31:0] clk_hz,
                                             input logic [31:0] speed_hz);
        logic [4:0]  a_tab[8];
        logic [31:0] target;
        logic [31:0] filt;
        logic [31:0] best;
        logic [31:0] cand;
        logic [31:0] bval;
        logic [3:0]  grp;
        t_result     r;
        a_tab = '{5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd24, 5'd30};
        if (speed_hz == 32'd0) begin
            target = 32'(TARGET_MAX);
        end else begin
            target = clk_hz / speed_hz;
            if (target > 32'(TARGET_MAX))
                target = 32'(TARGET_MAX);
        end
        filt = (32'd5 * (clk_hz / 32'd1000)) / 32'd100000;
        if (filt == 32'd0)
            filt = 32'd1;
        best              = '1;
        r.filter_count    = filt[7:0];
        r.divider_code    = DEFAULT_CODE;
        r.actual_speed_hz = speed_hz;
        r.divisor_found   = 1'b0;
        // A outer, B inner; strict compare keeps the first on a tie
        for (int ai = 0; ai < 8; ai++) begin
            grp = 4'(4 + ai);
            for (int g = 0; g < 8; g++) begin
                bval = 32'd16 << g;
                cand = bval * (32'(a_tab[ai]) + ((32'd3 * filt) / bval) * 32'd2);
                if (cand > target && cand < best) begin
                    best              = cand;
                    r.divider_code    = 6'((g << 2) | (grp & 4'h3) | ((grp & 4'h4) << 3));
                    r.actual_speed_hz = clk_hz / cand;
                    r.divisor_found   = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h expected 0x%08h (result %0d)",
                 what, got, want, result_count);
        error_count++;
    endtask

    // Known levels on every input from time zero
    initial begin
        req_ch.valid              = 1'b0;
        req_ch.requested_speed_hz = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.data               = '0;
        res_ch.ready              = 1'b0;
    end

    // Request driver: pops the pending queue once a transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(
                    pick_divider(clk_hz_shadow, req_ch.requested_speed_hz));
                void'(pending_speeds.pop_front());
                accepted_count++;
            end
            // An offered transaction is held until taken
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (tx_pause || pending_speeds.size() == 0 ||
                    $urandom_range(0, 99) < tx_idle_pct) begin
                    req_ch.valid <= 1'b0;
                end else begin
                    req_ch.valid              <= 1'b1;
                    req_ch.requested_speed_hz <= pending_speeds[0];
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transaction", 32'd1, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.filter_count !== want.filter_count)
                        report_mismatch("filter_count", 32'(res_ch.filter_count),
                                        32'(want.filter_count));
                    if (res_ch.divider_code !== want.divider_code)
                        report_mismatch("divider_code", 32'(res_ch.divider_code),
                                        32'(want.divider_code));
                    if (res_ch.actual_speed_hz !== want.actual_speed_hz)
                        report_mismatch("actual_speed_hz", res_ch.actual_speed_hz,
                                        want.actual_speed_hz);
                    if (res_ch.divisor_found !== want.divisor_found)
                        report_mismatch("divisor_found", 32'(res_ch.divisor_found),
                                        32'(want.divisor_found));
                    if (want.divisor_found)
                        found_count++;
                end
            end
            res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb_i2c_bus_divider_search_unit NOT OK");
            $finish;
        end
    end

    // Wait until the unit has drained, then allow for the pipeline depth
    task automatic wait_drained();
        while (pending_speeds.size() != 0 || req_ch.valid ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    // Write the input clock register through the config channel
    task automatic write_clock(input logic [31:0] hz);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= hz;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        clk_hz_shadow = hz;
        cfg_ch.valid <= 1'b0;
    endtask

    // Random speed: mixes raw words with speeds aimed at the candidate range
    function automatic logic [31:0] random_speed(input logic [31:0] clk_hz);
        logic [31:0] s;
        int unsigned tgt;
        case ($urandom_range(0, 4))
            0: s = $urandom;
            1: s = $urandom_range(1, 1000);
            2: s = $urandom_range(1, 5000000);
            default: begin
                // aim the target divider at or near the candidate grid
                tgt = $urandom_range(1, 70000);
                s   = clk_hz / tgt;
                if (s == 32'd0)
                    s = 32'd1;
            end
        endcase
        return s;
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_speeds.push_back(random_speed(clk_hz_shadow));
    endtask

    initial begin
        logic [31:0] clocks[$];
        int          batch;
        error_count    = 0;
        accepted_count = 0;
        result_count   = 0;
        found_count    = 0;
        cycle_count    = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        tx_pause       = 1'b0;
        rx_hold        = 1'b0;
        clk_hz_shadow  = CLK_RESET;

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset clock, field extremes, zero speed, edges of the grid
        pending_speeds.push_back(32'd0);             // zero speed, default code
        pending_speeds.push_back(32'd1);             // target saturates
        pending_speeds.push_back(32'hFFFF_FFFF);     // target zero
        pending_speeds.push_back(32'h8000_0000);
        pending_speeds.push_back(32'd100000);
        pending_speeds.push_back(32'd400000);
        pending_speeds.push_back(32'd1000000);
        pending_speeds.push_back(CLK_RESET / 61440); // just above largest candidate
        pending_speeds.push_back(CLK_RESET / 61439);
        pending_speeds.push_back(CLK_RESET / 61441);
        pending_speeds.push_back(CLK_RESET / 160);   // target below smallest candidates
        pending_speeds.push_back(CLK_RESET / 159);
        pending_speeds.push_back(32'h5555_5555);
        pending_speeds.push_back(32'hAAAA_AAAA);
        wait_drained();

        // Extreme clocks: minimum and maximum
        write_clock(32'd1000);
        pending_speeds.push_back(32'd0);
        pending_speeds.push_back(32'd1);
        pending_speeds.push_back(32'd1000);
        wait_drained();
        write_clock(32'hFFFF_FFFF);
        pending_speeds.push_back(32'd1);
        pending_speeds.push_back(32'd69906);         // just below largest candidate
        pending_speeds.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Random phases over a spread of clocks, cycling the idling modes
        clocks = '{32'd19999999, 32'd20000000, 32'd66666666, CLK_RESET,
                   32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd0};
        for (batch = 0; batch < 8; batch++) begin
            if (clocks[batch] == 32'd0)
                clocks[batch] = $urandom_range(1000, 32'hFFFF_FFFF);
            write_clock(clocks[batch]);
            case (batch % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 49; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 49; end
                default: begin tx_idle_pct = 37; rx_idle_pct = 37; end
            endcase
            queue_random(150);

            if (batch == 2) begin
                // Long receiver hold-off: output buffer fills and input stalls
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            if (batch == 5) begin
                // Sender pause until every owed result has arrived
                while (pending_speeds.size() > 75) @(posedge i_clk);
                tx_pause = 1'b1;
                while (req_ch.valid || expected_results.size() != 0) @(posedge i_clk);
                tx_pause = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d requests over %0d clock settings, %0d with a divisor found",
                 accepted_count, 11, found_count);
        $display("results checked: %0d, mismatches: %0d", result_count, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_i2c_bus_divider_search_unit OK");
        end else begin
            $display("tb_i2c_bus_divider_search_unit NOT OK");
        end
        $finish;
    end

endmodule
